@@ sv/wtsm_pkg.sv @@
// Shared constants, types and item layouts for the transmit slot manager.
package wtsm_pkg;

  localparam int SLOT_COUNT        = 5;
  localparam int DESCRIPTOR_STRIDE = 20;
  localparam int TAG_WIDTH         = 16;
  localparam int SLOT_IDX_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic        ACT_TX         = 1'b0;
  localparam logic        ACT_DONE       = 1'b1;
  localparam logic [4:0]  RATE_HT        = 5'h10;
  localparam logic [4:0]  RATE_SGI       = 5'h18;
  localparam logic [31:0] PLCP0_FLAGS    = 32'h0060_0000 | 32'hc000_0000;
  localparam logic [31:0] PLCP1_FLAG     = 32'h1000_0000;
  localparam logic [31:0] HT_SIG_FLAGS   = 32'h0700_0000;
  localparam logic [31:0] HT_LEN_FLAG    = 32'h0005_0000;
  localparam logic [16:0] DESC_OVERHEAD  = 17'd32;

  typedef struct packed {
    logic        action;
    logic [15:0] frame_tag;
    logic [15:0] frame_length;
    logic [4:0]  rate_code;
    logic [31:0] done_mask;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [4:0]  slot_index;
    logic [15:0] returned_tag;
    logic [7:0]  seq_byte_low;
    logic [7:0]  seq_byte_high;
    logic [16:0] descriptor_size;
    logic [31:0] plcp0_word;
    logic [31:0] plcp1_word;
    logic [31:0] ht_sig_word;
    logic [31:0] ht_length_word;
    logic        slot_freed;
    logic        calibrate;
  } out_item_t;

  typedef struct packed {
    logic                  claim_ok;
    logic [SLOT_IDX_W-1:0] claim_idx;
    logic                  bit_found;
    logic [4:0]            top_bit;
    logic                  freed;
    logic [15:0]           tag;
    logic [11:0]           seq;
    logic                  calibrate;
  } slot_res_t;

endpackage

@@ sv/wtsm_if.sv @@
// Handshake interfaces for request, result and configuration channels.
interface wtsm_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] frame_tag;
  logic [15:0] frame_length;
  logic [4:0]  rate_code;
  logic [31:0] done_mask;

  modport source (output valid, action, frame_tag, frame_length, rate_code, done_mask,
                  input ready);
  modport sink   (input valid, action, frame_tag, frame_length, rate_code, done_mask,
                  output ready);
endinterface

interface wtsm_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [4:0]  slot_index;
  logic [15:0] returned_tag;
  logic [7:0]  seq_byte_low;
  logic [7:0]  seq_byte_high;
  logic [16:0] descriptor_size;
  logic [31:0] plcp0_word;
  logic [31:0] plcp1_word;
  logic [31:0] ht_sig_word;
  logic [31:0] ht_length_word;
  logic        slot_freed;
  logic        calibrate;

  modport source (output valid, accepted, slot_index, returned_tag, seq_byte_low,
                  seq_byte_high, descriptor_size, plcp0_word, plcp1_word, ht_sig_word,
                  ht_length_word, slot_freed, calibrate, input ready);
  modport sink   (input valid, accepted, slot_index, returned_tag, seq_byte_low,
                  seq_byte_high, descriptor_size, plcp0_word, plcp1_word, ht_sig_word,
                  ht_length_word, slot_freed, calibrate, output ready);
endinterface

interface wtsm_cfg_if;
  logic        valid;
  logic        ready;
  logic [19:0] descriptor_base;

  modport source (output valid, descriptor_base, input ready);
  modport sink   (input valid, descriptor_base, output ready);
endinterface

@@ sv/wtsm_slots.sv @@
// Slot table: busy bits, stored tags, sequence and completion counters.
module wtsm_slots
  import wtsm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      commit_i,
  input  in_item_t  item_i,
  output slot_res_t res_o
);

  logic [SLOT_COUNT-1:0] busy_q, busy_d;
  logic [TAG_WIDTH-1:0]  tag_q [SLOT_COUNT];
  logic [11:0]           seq_q;
  logic [1:0]            cmpl_q;

  logic                  is_tx, is_done, free_ok, nz, in_range, freed;
  logic [SLOT_IDX_W-1:0] free_idx, done_idx;
  logic [4:0]            top;
  logic [31:0]           tag_wide, tag_in;

  assign is_tx   = (item_i.action == ACT_TX);
  assign is_done = (item_i.action == ACT_DONE);
  assign nz      = |item_i.done_mask;

  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_ok  = 1'b1;
        free_idx = SLOT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    top = '0;
    for (int i = 0; i < 32; i++) begin
      if (item_i.done_mask[i]) begin
        top = 5'(i);
      end
    end
  end

  assign in_range = (32'(top) < 32'(SLOT_COUNT));
  assign done_idx = top[SLOT_IDX_W-1:0];
  assign freed    = is_done && nz && in_range && busy_q[done_idx];
  assign tag_wide = in_range ? 32'(tag_q[done_idx]) : '0;
  assign tag_in   = 32'(item_i.frame_tag);

  always_comb begin
    res_o.claim_ok  = is_tx && free_ok;
    res_o.claim_idx = free_idx;
    res_o.bit_found = is_done && nz;
    res_o.top_bit   = top;
    res_o.freed     = freed;
    res_o.tag       = freed ? tag_wide[15:0] : '0;
    res_o.seq       = seq_q;
    res_o.calibrate = is_done && nz && (cmpl_q == 2'd3);
  end

  always_comb begin
    busy_d = busy_q;
    if (res_o.claim_ok) begin
      busy_d[free_idx] = 1'b1;
    end
    if (freed) begin
      busy_d[done_idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      seq_q  <= '0;
      cmpl_q <= '0;
    end else if (commit_i) begin
      busy_q <= busy_d;
      if (res_o.claim_ok) begin
        seq_q <= seq_q + 12'd1;
      end
      if (res_o.bit_found) begin
        cmpl_q <= cmpl_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i && res_o.claim_ok) begin
      tag_q[free_idx] <= tag_in[TAG_WIDTH-1:0];
    end
  end

  a_claim_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && res_o.claim_ok |=> busy_q[$past(free_idx)])
    else $error("claimed slot not marked busy");

  a_seq_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(commit_i && res_o.claim_ok) |=> $stable(seq_q))
    else $error("sequence number moved without a claim");

  a_free_clears_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && freed |=> !busy_q[$past(done_idx)])
    else $error("freed slot still busy");

  a_reject_all_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_tx && !res_o.claim_ok |-> (&busy_q))
    else $error("request rejected with a free slot");

endmodule

@@ sv/wtsm_fmt.sv @@
// Result formatter: descriptor size, PLCP, HT words or completion fields.
module wtsm_fmt
  import wtsm_pkg::*;
(
  input  in_item_t    item_i,
  input  slot_res_t   res_i,
  input  logic [19:0] base_i,
  output out_item_t   item_o
);

  logic        is_ht, sgi;
  logic [19:0] addr;
  logic [15:0] len;
  logic [4:0]  rate;

  assign len   = item_i.frame_length;
  assign rate  = item_i.rate_code;
  assign is_ht = (rate >= RATE_HT);
  assign sgi   = (rate >= RATE_SGI);
  assign addr  = base_i + 20'(32'(res_i.claim_idx) * 32'(DESCRIPTOR_STRIDE));

  always_comb begin
    item_o = '0;
    if (res_i.claim_ok) begin
      item_o.accepted        = 1'b1;
      item_o.slot_index      = 5'(res_i.claim_idx);
      item_o.seq_byte_low    = {res_i.seq[3:0], 4'b0};
      item_o.seq_byte_high   = res_i.seq[11:4];
      item_o.descriptor_size = 17'(len) + DESC_OVERHEAD;
      item_o.plcp0_word      = {12'b0, addr} | PLCP0_FLAGS;
      item_o.plcp1_word      = PLCP1_FLAG | {20'b0, len[11:0]} | {15'b0, rate, 12'b0}
                               | {6'b0, is_ht, 25'b0};
      if (is_ht) begin
        item_o.ht_sig_word    = {29'b0, rate[2:0]} | {8'b0, len, 8'b0} | HT_SIG_FLAGS
                                | {sgi, 31'b0};
        item_o.ht_length_word = {16'b0, len} | HT_LEN_FLAG;
      end
    end else if (res_i.bit_found) begin
      item_o.slot_index   = res_i.top_bit;
      item_o.returned_tag = res_i.tag;
      item_o.slot_freed   = res_i.freed;
      item_o.calibrate    = res_i.calibrate;
    end
  end

endmodule

@@ sv/wifi_tx_slot_manager_top.sv @@
// Top level of the transmit slot manager: input stage, slot table, result register.
//
// Channels: in_i takes requests (action 0: claim a slot, stamp the sequence
// number, build descriptor words) and completions (action 1: free the slot
// named by the highest set bit of done_mask). out_o returns exactly one
// result item per input item, in order. cfg_i writes descriptor_base and is
// always ready; write it only while no item is in flight.
// Path: an accepted item is registered in the input stage, resolved against
// the slot table and loaded into the result register, which drives
// out_o.valid; a stall at out_o holds it in the input stage.
// Throughput: one item per cycle while out_o does not stall; the slot table
// is read and updated in the same cycle as the result register loads, so
// back-to-back items see each other's claims and releases.
// Reset: all slots idle, sequence number and completion count zero,
// descriptor_base zero, both stages empty.
// Stall: while out_o.ready is low the result register holds, the input
// stage holds one more item, and in_i.ready drops once both are full.
module wifi_tx_slot_manager_top
  import wtsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  wtsm_in_if.sink     in_i,
  wtsm_out_if.source  out_o,
  wtsm_cfg_if.sink    cfg_i
);

  logic        s1_valid_q, out_valid_q, s1_adv, commit, in_fire;
  in_item_t    s1_q, in_item;
  out_item_t   out_q, fmt_item;
  slot_res_t   slot_res;
  logic [19:0] base_q;

  assign in_item.action       = in_i.action;
  assign in_item.frame_tag    = in_i.frame_tag;
  assign in_item.frame_length = in_i.frame_length;
  assign in_item.rate_code    = in_i.rate_code;
  assign in_item.done_mask    = in_i.done_mask;

  assign s1_adv     = !out_valid_q || out_o.ready;
  assign commit     = s1_valid_q && s1_adv;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (cfg_i.valid) begin
        base_q <= cfg_i.descriptor_base;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_item;
    end
    if (commit) begin
      out_q <= fmt_item;
    end
  end

  wtsm_slots u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit),
    .item_i   (s1_q),
    .res_o    (slot_res)
  );

  wtsm_fmt u_fmt (
    .item_i (s1_q),
    .res_i  (slot_res),
    .base_i (base_q),
    .item_o (fmt_item)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.accepted        = out_q.accepted;
  assign out_o.slot_index      = out_q.slot_index;
  assign out_o.returned_tag    = out_q.returned_tag;
  assign out_o.seq_byte_low    = out_q.seq_byte_low;
  assign out_o.seq_byte_high   = out_q.seq_byte_high;
  assign out_o.descriptor_size = out_q.descriptor_size;
  assign out_o.plcp0_word      = out_q.plcp0_word;
  assign out_o.plcp1_word      = out_q.plcp1_word;
  assign out_o.ht_sig_word     = out_q.ht_sig_word;
  assign out_o.ht_length_word  = out_q.ht_length_word;
  assign out_o.slot_freed      = out_q.slot_freed;
  assign out_o.calibrate       = out_q.calibrate;

endmodule

@@ tb/sv/wifi_tx_slot_manager_top_tb.sv @@
// Self-checking testbench for the transmit slot manager against a slot table model.
`timescale 1ns / 1ps

module wifi_tx_slot_manager_top_tb;
  import wtsm_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int CLAIM_ROUNDS = 40;
  localparam int RAND_ITEMS   = 95;

  typedef struct packed {
    logic [SLOT_COUNT-1:0]                busy;
    logic [SLOT_COUNT-1:0][TAG_WIDTH-1:0] tags;
    logic [11:0]                          seq;
    logic [1:0]                           done_cnt;
  } slot_table_t;

  logic clk_i;
  logic rst_ni;

  wtsm_in_if  in_if ();
  wtsm_out_if out_if ();
  wtsm_cfg_if cfg_if ();

  wifi_tx_slot_manager_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  in_item_t    pending_items[$];
  out_item_t   expected_results[$];
  slot_table_t gen_table;
  slot_table_t chk_table;
  logic [19:0] cur_base;
  logic        in_took;
  int          src_idle_pct;
  int          snk_stall_pct;
  int          cycle_cnt;
  int          n_fail;
  int          n_results;
  int          n_granted;
  int          n_refused;
  int          n_freed;
  int          n_calib;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic out_item_t resolve_item(inout slot_table_t tbl, input logic [19:0] base,
                                             input in_item_t it);
    out_item_t   res;
    int          slot_sel;
    int          top;
    logic        is_ht;
    logic        sgi;
    logic [19:0] addr;
    res = '0;
    slot_sel = -1;
    top = 0;
    if (it.action == ACT_TX) begin
      for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
        if (!tbl.busy[s]) slot_sel = s;
      end
      if (slot_sel >= 0) begin
        tbl.busy[slot_sel] = 1'b1;
        tbl.tags[slot_sel] = it.frame_tag[TAG_WIDTH-1:0];
        is_ht = (it.rate_code >= RATE_HT);
        sgi = (it.rate_code >= RATE_SGI);
        addr = base + 20'(slot_sel * DESCRIPTOR_STRIDE);
        res.accepted = 1'b1;
        res.slot_index = 5'(slot_sel);
        res.seq_byte_low = {tbl.seq[3:0], 4'h0};
        res.seq_byte_high = tbl.seq[11:4];
        res.descriptor_size = {1'b0, it.frame_length} + DESC_OVERHEAD;
        res.plcp0_word = {12'h0, addr} | PLCP0_FLAGS;
        res.plcp1_word = PLCP1_FLAG | {20'h0, it.frame_length[11:0]}
                         | {15'h0, it.rate_code, 12'h0} | {6'h0, is_ht, 25'h0};
        if (is_ht) begin
          res.ht_sig_word = {29'h0, it.rate_code[2:0]} | {8'h0, it.frame_length, 8'h0}
                            | HT_SIG_FLAGS | {sgi, 31'h0};
          res.ht_length_word = {16'h0, it.frame_length} | HT_LEN_FLAG;
        end
        tbl.seq = tbl.seq + 12'd1;
      end
    end else if (it.done_mask != 32'h0) begin
      for (int b = 0; b < 32; b++) begin
        if (it.done_mask[b]) top = b;
      end
      res.slot_index = 5'(top);
      tbl.done_cnt = tbl.done_cnt + 2'd1;
      res.calibrate = (tbl.done_cnt == 2'd0);
      if (top < SLOT_COUNT && tbl.busy[top]) begin
        res.returned_tag = tbl.tags[top];
        res.slot_freed = 1'b1;
        tbl.busy[top] = 1'b0;
      end
    end
    return res;
  endfunction

  task automatic queue_item(input in_item_t it, output out_item_t res);
    res = resolve_item(gen_table, 20'h0, it);
    pending_items.push_back(it);
  endtask

  function automatic in_item_t make_item(logic act, logic [15:0] tag, logic [15:0] len,
                                         logic [4:0] rate, logic [31:0] mask);
    in_item_t it;
    it.action = act;
    it.frame_tag = tag;
    it.frame_length = len;
    it.rate_code = rate;
    it.done_mask = mask;
    return it;
  endfunction

  function automatic logic [31:0] mask_with_top(int b);
    logic [31:0] low;
    low = (32'd1 << b) - 32'd1;
    return (32'd1 << b) | ($urandom & low);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it = make_item(ACT_TX, 16'($urandom), 16'($urandom), 5'($urandom), $urandom);
    if ($urandom_range(3) == 0) it.frame_length = $urandom_range(1) ? 16'hffff : 16'h0000;
    pick = $urandom_range(99);
    if (pick >= 50) begin
      it.action = ACT_DONE;
      if (pick < 85) it.done_mask = mask_with_top($urandom_range(SLOT_COUNT - 1));
      else if (pick < 93) it.done_mask = mask_with_top($urandom_range(31, SLOT_COUNT));
      else if (pick < 97) it.done_mask = 32'h0;
    end
    return it;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_results.size());
      $display("wifi_tx_slot_manager_top verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    in_item_t  it;
    out_item_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result item with nothing expected, slot_index %h", $time,
                   out_if.slot_index);
          n_fail++;
        end else begin
          want = expected_results.pop_front();
          n_results++;
          compare_field("accepted", 32'(want.accepted), 32'(out_if.accepted));
          compare_field("slot_index", 32'(want.slot_index), 32'(out_if.slot_index));
          compare_field("returned_tag", 32'(want.returned_tag), 32'(out_if.returned_tag));
          compare_field("seq_byte_low", 32'(want.seq_byte_low), 32'(out_if.seq_byte_low));
          compare_field("seq_byte_high", 32'(want.seq_byte_high), 32'(out_if.seq_byte_high));
          compare_field("descriptor_size", 32'(want.descriptor_size),
                        32'(out_if.descriptor_size));
          compare_field("plcp0_word", want.plcp0_word, out_if.plcp0_word);
          compare_field("plcp1_word", want.plcp1_word, out_if.plcp1_word);
          compare_field("ht_sig_word", want.ht_sig_word, out_if.ht_sig_word);
          compare_field("ht_length_word", want.ht_length_word, out_if.ht_length_word);
          compare_field("slot_freed", 32'(want.slot_freed), 32'(out_if.slot_freed));
          compare_field("calibrate", 32'(want.calibrate), 32'(out_if.calibrate));
        end
      end
      in_took = in_if.valid && in_if.ready;
      if (in_took) begin
        it = make_item(in_if.action, in_if.frame_tag, in_if.frame_length, in_if.rate_code,
                       in_if.done_mask);
        want = resolve_item(chk_table, cur_base, it);
        expected_results.push_back(want);
        if (it.action == ACT_TX) begin
          if (want.accepted) n_granted++;
          else n_refused++;
        end
        if (want.slot_freed) n_freed++;
        if (want.calibrate) n_calib++;
      end
      if (cfg_if.valid && cfg_if.ready) cur_base = cfg_if.descriptor_base;
    end
  end

  always @(negedge clk_i) begin
    in_item_t it;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        it = pending_items.pop_front();
        in_if.action <= it.action;
        in_if.frame_tag <= it.frame_tag;
        in_if.frame_length <= it.frame_length;
        in_if.rate_code <= it.rate_code;
        in_if.done_mask <= it.done_mask;
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  task automatic drain();
    while (pending_items.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_base(logic [19:0] value);
    @(negedge clk_i);
    cfg_if.descriptor_base <= value;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_random(int src_pct, int snk_pct, logic [19:0] base);
    out_item_t res;
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    write_base(base);
    for (int i = 0; i < RAND_ITEMS; i++) queue_item(random_item(), res);
    drain();
  endtask

  initial begin
    out_item_t res;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = ACT_TX;
    in_if.frame_tag = '0;
    in_if.frame_length = '0;
    in_if.rate_code = '0;
    in_if.done_mask = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.descriptor_base = '0;
    gen_table = '0;
    chk_table = '0;
    cur_base = '0;
    in_took = 1'b0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    cycle_cnt = 0;
    n_fail = 0;
    n_results = 0;
    n_granted = 0;
    n_refused = 0;
    n_freed = 0;
    n_calib = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_base(20'h00000);
    queue_item(make_item(ACT_TX, 16'h0000, 16'h0000, 5'h00, 32'h0000_0000), res);
    queue_item(make_item(ACT_TX, 16'hffff, 16'hffff, 5'h0f, 32'hffff_ffff), res);
    queue_item(make_item(ACT_TX, 16'h1234, 16'd1500, 5'h10, 32'h0000_0001), res);
    queue_item(make_item(ACT_TX, 16'h5a5a, 16'h0fff, 5'h17, 32'h0000_0000), res);
    queue_item(make_item(ACT_TX, 16'h00ff, 16'h1000, 5'h18, 32'h8000_0000), res);
    queue_item(make_item(ACT_TX, 16'hbeef, 16'h0040, 5'h1f, 32'h0000_0000), res);
    queue_item(make_item(ACT_DONE, 16'hffff, 16'hffff, 5'h1f, 32'h0000_0000), res);
    queue_item(make_item(ACT_DONE, 16'h0000, 16'h0000, 5'h00, 32'h8000_0000), res);
    queue_item(make_item(ACT_DONE, 16'h0000, 16'h0000, 5'h00, 32'h0000_0010), res);
    queue_item(make_item(ACT_DONE, 16'h0000, 16'h0000, 5'h00, 32'h0000_0010), res);
    queue_item(make_item(ACT_DONE, 16'h0000, 16'h0000, 5'h00, 32'h0000_000c), res);
    queue_item(make_item(ACT_TX, 16'ha5a5, 16'hffff, 5'h1f, 32'h0000_0000), res);
    queue_item(make_item(ACT_DONE, 16'h0000, 16'h0000, 5'h00, 32'h0000_0001), res);
    queue_item(make_item(ACT_DONE, 16'h0000, 16'h0000, 5'h00, 32'h0000_0020), res);
    queue_item(make_item(ACT_DONE, 16'h0000, 16'h0000, 5'h00, 32'h0000_0007), res);
    queue_item(make_item(ACT_DONE, 16'h0000, 16'h0000, 5'h00, 32'h0000_0002), res);
    queue_item(make_item(ACT_DONE, 16'h0000, 16'h0000, 5'h00, 32'h0000_0008), res);
    queue_item(make_item(ACT_DONE, 16'h0000, 16'h0000, 5'h00, 32'h0000_0001), res);
    queue_item(make_item(ACT_TX, 16'h8000, 16'h8000, 5'h10, 32'h7fff_ffff), res);
    queue_item(make_item(ACT_DONE, 16'hffff, 16'hffff, 5'h1f, 32'hffff_ffff), res);
    queue_item(make_item(ACT_DONE, 16'h0000, 16'h0000, 5'h00, 32'h0000_0001), res);
    drain();

    // interleave claims with releases of the slot just claimed
    for (int i = 0; i < CLAIM_ROUNDS; i++) begin
      queue_item(random_item(), res);
      queue_item(make_item(ACT_TX, 16'($urandom), 16'($urandom), 5'($urandom), $urandom),
                 res);
      if (res.accepted) queue_item(make_item(ACT_DONE, 16'($urandom), 16'($urandom),
                                             5'($urandom), mask_with_top(res.slot_index)),
                                   res);
    end
    drain();

    run_random(0, 0, 20'hfffff);
    run_random(47, 0, 20'hfffff - 20'd45);
    run_random(0, 47, 20'($urandom));
    run_random(38, 38, 20'h00000);
    run_random(0, 0, 20'($urandom));

    repeat (8) @(posedge clk_i);
    $display("checked %0d result items: %0d slots claimed, %0d requests refused",
             n_results, n_granted, n_refused);
    $display("%0d slots released, %0d calibrate pulses, %0d mismatches",
             n_freed, n_calib, n_fail);
    if (n_fail == 0) begin
      $display("wifi_tx_slot_manager_top verification clean");
    end else begin
      $display("wifi_tx_slot_manager_top verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/wtsm_pkg.sv
sv/wtsm_if.sv
sv/wtsm_slots.sv
sv/wtsm_fmt.sv
sv/wifi_tx_slot_manager_top.sv
tb/sv/wifi_tx_slot_manager_top_tb.sv
